/* design/lpmr_pkg.sv */
// Package for the length-prefixed message ring: sizes, action and status codes,
// controller states, result record and pointer helpers.
// No dependencies.
`default_nettype none

package lpmr_pkg;

  localparam int BUF_BYTES = 4096;
  localparam int RSV_BYTES = 8;
  localparam int PFX_BYTES = 4;
  localparam int PTR_W     = $clog2(BUF_BYTES);
  localparam int LEN_W     = 12;
  localparam int BYTE_W    = 8;
  // wide enough for prefix + length + used + gap without overflow
  localparam int SUM_W     = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 2;

  typedef enum logic [1:0] {
    ACT_BEGIN_PUSH = 2'd0,
    ACT_PUSH_BYTE  = 2'd1,
    ACT_BEGIN_POP  = 2'd2,
    ACT_POP_BYTE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_LENGTH = 3'd1,
    ST_NO_SPACE   = 3'd2,
    ST_TOO_LARGE  = 3'd3,
    ST_EMPTY      = 3'd4,
    ST_SEQUENCE   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_PFX_WR,
    FSM_POP_RD,
    FSM_BYTE_RD
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [BYTE_W-1:0]   data_out;
    logic [LEN_W-1:0]    head_length;
    logic                last_byte;
    logic [LEN_W-1:0]    used_bytes;
    logic                is_empty;
    logic                is_full;
  } res_t;

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] pos);
    return (pos == PTR_W'(BUF_BYTES - 1)) ? '0 : pos + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] used_of(input logic [PTR_W-1:0] wp,
                                               input logic [PTR_W-1:0] rp);
    logic [PTR_W:0] wrapped;
    wrapped = (PTR_W + 1)'(BUF_BYTES) + {1'b0, wp} - {1'b0, rp};
    return (wp >= rp) ? (wp - rp) : wrapped[PTR_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/length_prefixed_message_ring_unit.sv */
// Timing: errors and push_byte give their result straight from the idle state, registered in
//   the output register (or the skid entry); pop_byte reads the store, then returns the byte;
//   begin_push writes the prefix a byte a cycle through the single write port; begin_pop makes four prefix reads.
// Throughput: push_byte one a cycle while the skid entry is free; other items take no new request until done.
// Reset (rst_n low, synchronous) clears pointers, counters and controller state.
// The byte store is not cleared: only committed bytes are ever read.
// Depends on lpmr_pkg and lpmr_ram.
`default_nettype none

module length_prefixed_message_ring_unit
  import lpmr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_action,
  input  wire logic [LEN_W-1:0]  in_message_length,
  input  wire logic [BYTE_W-1:0] in_data_in,
  input  wire logic [LEN_W-1:0]  in_reader_capacity,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_status,
  output logic [BYTE_W-1:0]      out_data_out,
  output logic [LEN_W-1:0]       out_head_length,
  output logic                   out_last_byte,
  output logic [LEN_W-1:0]       out_used_bytes,
  output logic                   out_is_empty,
  output logic                   out_is_full
);

  state_t            state_r, state_nxt;
  logic [PTR_W-1:0]  rp_r, rp_nxt;
  logic [PTR_W-1:0]  wp_r, wp_nxt;
  logic [PTR_W-1:0]  push_cur_r, push_cur_nxt;
  logic [LEN_W-1:0]  push_rem_r, push_rem_nxt;
  logic [PTR_W-1:0]  pop_cur_r, pop_cur_nxt;
  logic [LEN_W-1:0]  pop_rem_r, pop_rem_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LEN_W-1:0]  cap_r, cap_nxt;
  logic              hinz_r, hinz_nxt;
  logic [1:0]        cnt_r, cnt_nxt;

  logic              out_valid_r, skid_valid_r;
  res_t              out_r, skid_r, res;
  logic              res_fire;
  logic              take;
  logic              accept;

  logic              wr_en, rd_en;
  logic [PTR_W-1:0]  wr_addr, rd_addr;
  logic [BYTE_W-1:0] wr_data, rd_data;

  logic [PTR_W-1:0]  used_cur, used_post;
  logic [SUM_W-1:0]  need_sum, full_sum;
  action_t           act;

  assign act      = action_t'(in_action);
  assign in_ready = (state_r == FSM_IDLE) && !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign take     = out_valid_r && out_ready;
  assign used_cur = used_of(wp_r, rp_r);
  assign need_sum = SUM_W'(PFX_BYTES) + SUM_W'(in_message_length) + SUM_W'(used_cur)
                  + SUM_W'(RSV_BYTES);

  lpmr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUF_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r       <= '0;
      wp_r       <= '0;
      push_cur_r <= '0;
      push_rem_r <= '0;
      pop_cur_r  <= '0;
      pop_rem_r  <= '0;
      cnt_r      <= '0;
    end else begin
      rp_r       <= rp_nxt;
      wp_r       <= wp_nxt;
      push_cur_r <= push_cur_nxt;
      push_rem_r <= push_rem_nxt;
      pop_cur_r  <= pop_cur_nxt;
      pop_rem_r  <= pop_rem_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    cap_r  <= cap_nxt;
    hinz_r <= hinz_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    push_cur_nxt = push_cur_r;
    push_rem_nxt = push_rem_r;
    pop_cur_nxt  = pop_cur_r;
    pop_rem_nxt  = pop_rem_r;
    len_nxt      = len_r;
    cap_nxt      = cap_r;
    hinz_nxt     = hinz_r;
    cnt_nxt      = cnt_r;
    wr_en        = 1'b0;
    wr_addr      = push_cur_r;
    wr_data      = '0;
    rd_en        = 1'b0;
    rd_addr      = pop_cur_r;
    res_fire     = 1'b0;
    res          = '0;
    res.status   = ST_OK;

    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          case (act)
            ACT_BEGIN_PUSH: begin
              if (push_rem_r != '0) begin
                res.status = ST_SEQUENCE;
                res_fire   = 1'b1;
              end else if (in_message_length == '0) begin
                res.status = ST_BAD_LENGTH;
                res_fire   = 1'b1;
              end else if (need_sum > SUM_W'(BUF_BYTES)) begin
                res.status = ST_NO_SPACE;
                res_fire   = 1'b1;
              end else begin
                // low prefix byte now, the other three in FSM_PFX_WR
                wr_en        = 1'b1;
                wr_addr      = wp_r;
                wr_data      = in_message_length[7:0];
                push_cur_nxt = ptr_adv(wp_r);
                len_nxt      = in_message_length;
                cnt_nxt      = 2'd1;
                state_nxt    = FSM_PFX_WR;
              end
            end
            ACT_PUSH_BYTE: begin
              res_fire = 1'b1;
              if (push_rem_r == '0) begin
                res.status = ST_SEQUENCE;
              end else begin
                wr_en        = 1'b1;
                wr_addr      = push_cur_r;
                wr_data      = in_data_in;
                push_cur_nxt = ptr_adv(push_cur_r);
                push_rem_nxt = push_rem_r - 1'b1;
                if (push_rem_r == LEN_W'(1)) begin
                  wp_nxt        = push_cur_nxt;
                  res.last_byte = 1'b1;
                end
              end
            end
            ACT_BEGIN_POP: begin
              if (pop_rem_r != '0) begin
                res.status = ST_SEQUENCE;
                res_fire   = 1'b1;
              end else if (in_reader_capacity == '0) begin
                res.status = ST_BAD_LENGTH;
                res_fire   = 1'b1;
              end else if (rp_r == wp_r) begin
                res.status = ST_EMPTY;
                res_fire   = 1'b1;
              end else begin
                rd_en       = 1'b1;
                rd_addr     = rp_r;
                pop_cur_nxt = ptr_adv(rp_r);
                cap_nxt     = in_reader_capacity;
                len_nxt     = '0;
                hinz_nxt    = 1'b0;
                cnt_nxt     = 2'd0;
                state_nxt   = FSM_POP_RD;
              end
            end
            ACT_POP_BYTE: begin
              if (pop_rem_r == '0) begin
                res.status = ST_SEQUENCE;
                res_fire   = 1'b1;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = pop_cur_r;
                state_nxt = FSM_BYTE_RD;
              end
            end
            default: begin
              res.status = ST_SEQUENCE;
              res_fire   = 1'b1;
            end
          endcase
        end
      end

      FSM_PFX_WR: begin
        wr_en        = 1'b1;
        wr_addr      = push_cur_r;
        wr_data      = (cnt_r == 2'd1) ? {{(BYTE_W - (LEN_W - 8)){1'b0}}, len_r[LEN_W-1:8]}
                                       : '0;
        push_cur_nxt = ptr_adv(push_cur_r);
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == 2'd3) begin
          push_rem_nxt = len_r;
          res_fire     = 1'b1;
          state_nxt    = FSM_IDLE;
        end
      end

      FSM_POP_RD: begin
        case (cnt_r)
          2'd0:    len_nxt[7:0] = rd_data;
          2'd1: begin
            len_nxt[LEN_W-1:8] = rd_data[LEN_W-9:0];
            hinz_nxt           = hinz_r | (|rd_data[BYTE_W-1:LEN_W-8]);
          end
          default: hinz_nxt = hinz_r | (|rd_data);
        endcase
        if (cnt_r != 2'd3) begin
          rd_en       = 1'b1;
          rd_addr     = pop_cur_r;
          pop_cur_nxt = ptr_adv(pop_cur_r);
          cnt_nxt     = cnt_r + 1'b1;
        end else begin
          // too large: message stays queued, nothing moves
          res.head_length = len_nxt;
          res_fire        = 1'b1;
          state_nxt       = FSM_IDLE;
          if (hinz_nxt || (len_nxt > cap_r)) begin
            res.status = ST_TOO_LARGE;
          end else begin
            pop_rem_nxt = len_nxt;
          end
        end
      end

      FSM_BYTE_RD: begin
        res.data_out = rd_data;
        pop_cur_nxt  = ptr_adv(pop_cur_r);
        pop_rem_nxt  = pop_rem_r - 1'b1;
        if (pop_rem_r == LEN_W'(1)) begin
          rp_nxt        = pop_cur_nxt;
          res.last_byte = 1'b1;
        end
        res_fire  = 1'b1;
        state_nxt = FSM_IDLE;
      end

      default: state_nxt = FSM_IDLE;
    endcase

    used_post      = used_of(wp_nxt, rp_nxt);
    full_sum       = SUM_W'(used_post) + SUM_W'(RSV_BYTES);
    res.used_bytes = LEN_W'(used_post);
    res.is_empty   = (rp_nxt == wp_nxt);
    res.is_full    = (full_sum >= SUM_W'(BUF_BYTES));
  end

  // Output register plus one skid entry; a new request is refused while the skid is full or the controller is busy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (res_fire) begin
        if (!out_valid_r || take) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (take) begin
        out_valid_r  <= skid_valid_r;
        skid_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_fire) begin
      if (!out_valid_r || take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end else if (take && skid_valid_r) begin
      out_r <= skid_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.status;
  assign out_data_out    = out_r.data_out;
  assign out_head_length = out_r.head_length;
  assign out_last_byte   = out_r.last_byte;
  assign out_used_bytes  = out_r.used_bytes;
  assign out_is_empty    = out_r.is_empty;
  assign out_is_full     = out_r.is_full;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without output entry");

  a_res_skid_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |-> !skid_valid_r)
    else $error("result produced while skid entry occupied");

  a_single_port_use: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("store read and written in the same cycle");

  a_open_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_rem_r != '0) |-> (rp_r != wp_r))
    else $error("pop open on an empty store");

  a_prefix_no_push_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_PFX_WR) |-> (push_rem_r == '0))
    else $error("prefix write while a push is open");
`endif

endmodule

`default_nettype wire

/* design/lpmr_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module lpmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* tb/sv/length_prefixed_message_ring_unit_tb.sv */
// Testbench for length_prefixed_message_ring_unit: a directed pass, a long receiver hold-off
// and random message traffic, all scored against a local model of the ring.
// Depends on lpmr_pkg and the unit itself.
`timescale 1ns / 100ps

module length_prefixed_message_ring_unit_tb
  import lpmr_pkg::*;
();

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int          RANDOM_ITEMS = 1100;
  localparam int          HOLD_CYCLES  = 600;

  typedef enum int {RX_STEADY, RX_HALF, RX_MOSTLY, RX_PATTERN} rx_mode_t;

  typedef struct {
    status_t           status;
    logic [BYTE_W-1:0] data_out;
    logic [LEN_W-1:0]  head_length;
    logic              last_byte;
    logic [LEN_W-1:0]  used_bytes;
    logic              is_empty;
    logic              is_full;
  } ring_reply_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_action = ACT_PUSH_BYTE;
  logic [LEN_W-1:0]  in_message_length = '0;
  logic [BYTE_W-1:0] in_data_in = '0;
  logic [LEN_W-1:0]  in_reader_capacity = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        out_status;
  logic [BYTE_W-1:0] out_data_out;
  logic [LEN_W-1:0]  out_head_length;
  logic              out_last_byte;
  logic [LEN_W-1:0]  out_used_bytes;
  logic              out_is_empty;
  logic              out_is_full;

  // local copy of the ring
  logic [7:0] ring_mem [BUF_BYTES];
  int rd_at = 0, wr_at = 0, push_at = 0, push_left = 0, pop_at = 0, pop_left = 0;

  ring_reply_t replies_due[$];
  int          mismatches = 0;
  int          replies_seen = 0;
  int          req_sent = 0;
  int unsigned cycles = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          mode_left = 0;
  rx_mode_t    rx_mode = RX_STEADY;

  length_prefixed_message_ring_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_message_length  (in_message_length),
    .in_data_in         (in_data_in),
    .in_reader_capacity (in_reader_capacity),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_data_out       (out_data_out),
    .out_head_length    (out_head_length),
    .out_last_byte      (out_last_byte),
    .out_used_bytes     (out_used_bytes),
    .out_is_empty       (out_is_empty),
    .out_is_full        (out_is_full)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int stored_bytes();
    return (wr_at + BUF_BYTES - rd_at) % BUF_BYTES;
  endfunction

  // Applies one request to the local ring and queues the reply it must produce.
  function automatic void predict_ring_reply(action_t act, logic [LEN_W-1:0] len,
                                             logic [BYTE_W-1:0] din, logic [LEN_W-1:0] cap);
    ring_reply_t r;
    int at;
    int plen;
    int i;
    r.status      = ST_OK;
    r.data_out    = '0;
    r.head_length = '0;
    r.last_byte   = 1'b0;
    case (act)
      ACT_BEGIN_PUSH: begin
        if (push_left != 0) r.status = ST_SEQUENCE;
        else if (len == 0) r.status = ST_BAD_LENGTH;
        else if (PFX_BYTES + int'(len) > BUF_BYTES - stored_bytes() - RSV_BYTES)
          r.status = ST_NO_SPACE;
        else begin
          at = wr_at;
          for (i = 0; i < PFX_BYTES; i++) begin
            ring_mem[at] = 8'(len >> (8 * i));
            at = (at + 1) % BUF_BYTES;
          end
          push_at   = at;
          push_left = int'(len);
        end
      end
      ACT_PUSH_BYTE: begin
        if (push_left == 0) r.status = ST_SEQUENCE;
        else begin
          ring_mem[push_at] = din;
          push_at = (push_at + 1) % BUF_BYTES;
          push_left--;
          if (push_left == 0) begin
            wr_at = push_at;
            r.last_byte = 1'b1;
          end
        end
      end
      ACT_BEGIN_POP: begin
        if (pop_left != 0) r.status = ST_SEQUENCE;
        else if (cap == 0) r.status = ST_BAD_LENGTH;
        else if (rd_at == wr_at) r.status = ST_EMPTY;
        else begin
          at = rd_at;
          plen = 0;
          for (i = 0; i < PFX_BYTES; i++) begin
            plen |= int'(ring_mem[at]) << (8 * i);
            at = (at + 1) % BUF_BYTES;
          end
          r.head_length = LEN_W'(plen);
          if (plen > int'(cap)) r.status = ST_TOO_LARGE;
          else begin
            pop_at   = at;
            pop_left = plen;
          end
        end
      end
      default: begin
        if (pop_left == 0) r.status = ST_SEQUENCE;
        else begin
          r.data_out = ring_mem[pop_at];
          pop_at = (pop_at + 1) % BUF_BYTES;
          pop_left--;
          if (pop_left == 0) begin
            rd_at = pop_at;
            r.last_byte = 1'b1;
          end
        end
      end
    endcase
    r.used_bytes = LEN_W'(stored_bytes());
    r.is_empty   = (rd_at == wr_at);
    r.is_full    = (BUF_BYTES - stored_bytes() - RSV_BYTES <= 0);
    replies_due.push_back(r);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("MISMATCH %s: got %0d, want %0d (reply %0d, cycle %0d)",
             what, got, want, replies_seen, cycles);
  endtask

  // Receiver: random stall modes, plus a long hold-off when asked for.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (mode_left == 0) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 3));
      mode_left = $urandom_range(50, 300);
    end else begin
      mode_left--;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: out_ready <= 1'b1;
        RX_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        default:   out_ready <= ((mode_left % 7) < 3);
      endcase
    end
  end

  // Reply scoreboard
  always @(posedge clk) begin
    ring_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        report_mismatch("reply with none due, status", out_status, -1);
      end else begin
        want = replies_due.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_data_out !== want.data_out)
          report_mismatch("data_out", out_data_out, want.data_out);
        if (out_head_length !== want.head_length)
          report_mismatch("head_length", out_head_length, want.head_length);
        if (out_last_byte !== want.last_byte)
          report_mismatch("last_byte", out_last_byte, want.last_byte);
        if (out_used_bytes !== want.used_bytes)
          report_mismatch("used_bytes", out_used_bytes, want.used_bytes);
        if (out_is_empty !== want.is_empty)
          report_mismatch("is_empty", out_is_empty, want.is_empty);
        if (out_is_full !== want.is_full)
          report_mismatch("is_full", out_is_full, want.is_full);
      end
    end
  end

  // Offers one request and holds it until taken; gaps follow a burst when enabled.
  task automatic send_req(action_t act, logic [LEN_W-1:0] len, logic [BYTE_W-1:0] din,
                          logic [LEN_W-1:0] cap);
    in_valid           <= 1'b1;
    in_action          <= act;
    in_message_length  <= len;
    in_data_in         <= din;
    in_reader_capacity <= cap;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_ring_reply(act, len, din, cap);
    req_sent++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic req_begin_push(int len);
    send_req(ACT_BEGIN_PUSH, LEN_W'(len), BYTE_W'($urandom), LEN_W'($urandom));
  endtask

  task automatic req_push_byte(int b);
    send_req(ACT_PUSH_BYTE, LEN_W'($urandom), BYTE_W'(b), LEN_W'($urandom));
  endtask

  task automatic req_begin_pop(int cap);
    send_req(ACT_BEGIN_POP, LEN_W'($urandom), BYTE_W'($urandom), LEN_W'(cap));
  endtask

  task automatic req_pop_byte();
    send_req(ACT_POP_BYTE, LEN_W'($urandom), BYTE_W'($urandom), LEN_W'($urandom));
  endtask

  task automatic push_msg(int len);
    req_begin_push(len);
    while (push_left != 0) req_push_byte($urandom_range(0, 255));
  endtask

  task automatic pop_msg(int cap);
    req_begin_pop(cap);
    while (pop_left != 0) req_pop_byte();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_basic_requests();
    req_push_byte(8'hA5);           // byte with nothing open
    req_pop_byte();
    req_begin_pop(5);               // empty store
    req_begin_pop(0);               // zero capacity wins over empty
    req_begin_push(0);
    req_begin_push(4095);           // can never fit
    req_begin_push(BUF_BYTES - RSV_BYTES - PFX_BYTES + 1);  // one byte over the room
    req_begin_push(2);
    req_begin_push(3);              // push already open
    req_begin_pop(4095);            // nothing committed yet
    req_push_byte(8'h00);
    req_push_byte(8'hFF);
    req_begin_pop(1);               // too large, stays queued
    req_begin_pop(4095);
    req_begin_pop(4095);            // pop already open
    req_pop_byte();
    req_pop_byte();
    req_pop_byte();
    push_msg(1);
    pop_msg(1);
  endtask

  task automatic test_receiver_hold();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    push_msg(30);
    pop_msg(4095);
    gaps_on  = 1'b1;
  endtask

  task automatic test_random_traffic();
    int first;
    int r;
    int len;
    int cap;
    first = req_sent;
    while (req_sent - first < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // noise: any request, mostly illegal in the current state
        len = (push_left != 0) ? $urandom_range(0, 4095) : $urandom_range(0, 20);
        send_req(action_t'($urandom_range(0, 3)), LEN_W'(len), BYTE_W'($urandom),
                 LEN_W'($urandom));
      end else begin
        r = $urandom_range(0, 9);
        r = $urandom_range(0, 99);
        if (r < 70) len = $urandom_range(1, 8);
        else if (r < 95) len = $urandom_range(9, 64);
        else len = $urandom_range(65, 400);
        r = $urandom_range(0, 99);
        if (r < 5) cap = 0;
        else if (r < 15) cap = $urandom_range(1, 8);
        else cap = $urandom_range(400, 4095);
        r = $urandom_range(0, 9);
        if (push_left != 0 && r < 4) req_push_byte($urandom_range(0, 255));
        else if (pop_left != 0 && r >= 4 && r < 8) req_pop_byte();
        else if (push_left == 0 && r < 6) req_begin_push(len);
        else if (pop_left == 0 && rd_at != wr_at) req_begin_pop(cap);
        else if (push_left != 0) req_push_byte($urandom_range(0, 255));
        else if (pop_left != 0) req_pop_byte();
        else req_begin_push(len);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_requests();
    wait_drained();
    test_receiver_hold();
    test_random_traffic();
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
